// ===== sv/assert_macros.svh =====
// assertion macros used by the top level rtl file
// expects signals clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

// ===== sv/ifrl_pkg.sv =====
// types and constants for the ipv4 forward route lookup block
// no dependencies
package ifrl_pkg;

    // item actions
    typedef enum logic [1:0] {
        ACTION_CLEAR  = 2'd0,
        ACTION_ADD    = 2'd1,
        ACTION_HEADER = 2'd2
    } action_t;

    // result verdicts
    typedef enum logic [1:0] {
        VERDICT_FORWARD  = 2'd0,
        VERDICT_LOCAL    = 2'd1,
        VERDICT_TTL_DROP = 2'd2,
        VERDICT_NO_ROUTE = 2'd3
    } verdict_t;

    // header word positions
    localparam logic [4:0] WORD_FIRST    = 5'd0;
    localparam logic [4:0] WORD_TTL      = 5'd4;
    localparam logic [4:0] WORD_CHECKSUM = 5'd5;
    localparam logic [4:0] WORD_DEST_HI  = 5'd8;
    localparam logic [4:0] WORD_DEST_LO  = 5'd9;
    localparam logic [4:0] WORD_LIMIT    = 5'd31;

    // one route table entry
    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  length;
        logic [31:0] hop;
    } route_t;

    // prefix mask for a prefix length, lengths past 32 act as 32
    function automatic logic [31:0] mask_of(input logic [5:0] len);
        logic [5:0] shift;
        shift = 6'd32 - len;
        if (len >= 6'd32)
        begin
            mask_of = 32'hffff_ffff;
        end
        else
        begin
            mask_of = 32'hffff_ffff << shift;
        end
    endfunction

endpackage

// ===== sv/ifrl_route_table.sv =====
// route table memory with a registered read port and prefix compare
// depends on ifrl_pkg
module ifrl_route_table #(
    parameter int ROUTE_ENTRIES = 16,
    parameter int IDX_W = 4
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  ifrl_pkg::route_t    wr_entry,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    input  logic [31:0]         destination,
    output logic                rd_match,
    output logic [31:0]         rd_hop
);
    import ifrl_pkg::*;

    route_t      mem [ROUTE_ENTRIES];
    route_t      rd_entry_reg;
    logic [31:0] mask;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    // masked prefix compare on the entry just read
    always_comb
    begin
        mask     = mask_of(rd_entry_reg.length);
        rd_match = (rd_entry_reg.prefix & mask) == (destination & mask);
        rd_hop   = rd_entry_reg.hop;
    end

endmodule

// ===== sv/ipv4_forward_route_lookup.sv =====
// top level of the ipv4 forward route lookup block: header parse,
// sequencer over the route table, output register; uses ifrl_pkg, ifrl_route_table, assert_macros.svh
//
// channel   signals                                        direction
// input     in_valid in_ready action route_prefix ...      in
// output    out_valid out_ready verdict forward_hop ...     out
// config    cfg_write_en cfg_write_data                    in
//
// clear, add and non-final header words leave the sequencer idle and in_ready high.
// a final header word keeps in_ready low through the eval, walk and put states; the walk
// is skipped when ttl, local address or an empty table decide, else it reads from 1 up to
// the entry count entries; the single table read port checks one entry a cycle.
// reset empties the table count and packet state; entries need no clearing.
// a result waiting on out_ready holds the sequencer in its final state.
module ipv4_forward_route_lookup #(
    parameter int ROUTE_ENTRIES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [31:0]           route_prefix,
    input  logic [5:0]            prefix_length,
    input  logic [31:0]           next_hop,
    input  logic [15:0]           header_word,
    input  logic                  last_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ifrl_pkg::verdict_t    verdict,
    output logic [31:0]           forward_hop,
    output logic [7:0]            new_ttl,
    output logic [15:0]           new_checksum,
    input  logic                  cfg_write_en,
    input  logic [31:0]           cfg_write_data
);
    import ifrl_pkg::*;
    `include "assert_macros.svh"

    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] ENTRIES = CNT_W'(ROUTE_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_WALK = 4'b0100,
        S_PUT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [31:0]       local_address_reg;
    logic [CNT_W-1:0]  entry_count_reg, entry_count_next;
    logic [CNT_W-1:0]  walk_idx_reg, walk_idx_next;
    logic [4:0]        word_index_reg, word_index_next;
    logic [3:0]        header_words_reg, header_words_next;
    logic [7:0]        seen_ttl_reg, seen_ttl_next;
    logic [31:0]       seen_dest_reg, seen_dest_next;
    logic [20:0]       running_sum_reg, running_sum_next;
    verdict_t          res_verdict_reg, res_verdict_next;
    logic [31:0]       res_hop_reg, res_hop_next;
    logic [7:0]        res_ttl_reg, res_ttl_next;
    logic [15:0]       res_csum_reg, res_csum_next;
    logic              out_valid_reg;
    verdict_t          out_verdict_reg;
    logic [31:0]       out_hop_reg;
    logic [7:0]        out_ttl_reg;
    logic [15:0]       out_csum_reg;

    logic              accept;
    logic              is_header;
    logic              tbl_wr;
    route_t            tbl_entry;
    logic              rd_en;
    logic [CNT_W-1:0]  rd_idx;
    logic              rd_match;
    logic [31:0]       rd_hop;
    logic              out_load;
    logic [16:0]       fold1;
    logic [16:0]       fold2;
    logic [15:0]       checksum;
    logic [3:0]        hw_base;
    logic [7:0]        ttl_base;
    logic [31:0]       dest_base;
    logic [20:0]       sum_base;
    logic [15:0]       add_word;
    logic [7:0]        ttl_dec;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign is_header = accept && (action == ACTION_HEADER);
    assign tbl_wr    = accept && (action == ACTION_ADD) && (entry_count_reg < ENTRIES);
    assign tbl_entry = '{prefix: route_prefix, length: prefix_length, hop: next_hop};
    assign out_load  = (state_reg == S_PUT) && (!out_valid_reg || out_ready);

    ifrl_route_table #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .clk         (clk),
        .wr_en       (tbl_wr),
        .wr_addr     (entry_count_reg[IDX_W-1:0]),
        .wr_entry    (tbl_entry),
        .rd_en       (rd_en),
        .rd_addr     (rd_idx[IDX_W-1:0]),
        .destination (seen_dest_reg),
        .rd_match    (rd_match),
        .rd_hop      (rd_hop)
    );

    // checksum fold of the running sum and ttl decrement
    always_comb
    begin
        fold1    = {1'b0, running_sum_reg[15:0]} + {12'd0, running_sum_reg[20:16]};
        fold2    = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
        checksum = ~fold2[15:0];
        ttl_dec  = seen_ttl_reg - 8'd1;
    end

    // packet state starts fresh at word zero
    always_comb
    begin
        if (word_index_reg == WORD_FIRST)
        begin
            hw_base   = header_word[11:8];
            ttl_base  = 8'd0;
            dest_base = 32'd0;
            sum_base  = 21'd0;
        end
        else
        begin
            hw_base   = header_words_reg;
            ttl_base  = seen_ttl_reg;
            dest_base = seen_dest_reg;
            sum_base  = running_sum_reg;
        end
    end

    // table count update and header word parse
    always_comb
    begin
        header_words_next = header_words_reg;
        seen_ttl_next     = seen_ttl_reg;
        seen_dest_next    = seen_dest_reg;
        running_sum_next  = running_sum_reg;
        word_index_next   = word_index_reg;
        entry_count_next  = entry_count_reg;
        add_word = header_word;
        if (accept && (action == ACTION_CLEAR))
        begin
            entry_count_next = '0;
        end
        if (tbl_wr)
        begin
            entry_count_next = CNT_W'(entry_count_reg + 1'b1);
        end
        if (is_header)
        begin
            header_words_next = hw_base;
            seen_ttl_next     = ttl_base;
            seen_dest_next    = dest_base;
            case (word_index_reg)
                WORD_TTL:
                begin
                    seen_ttl_next = header_word[15:8];
                    add_word      = {header_word[15:8] - 8'd1, header_word[7:0]};
                end
                WORD_CHECKSUM:
                begin
                    add_word = 16'd0;
                end
                WORD_DEST_HI:
                begin
                    seen_dest_next = {header_word, dest_base[15:0]};
                end
                WORD_DEST_LO:
                begin
                    seen_dest_next = {dest_base[31:16], header_word};
                end
                default:
                begin
                    add_word = header_word;
                end
            endcase
            if (word_index_reg < {hw_base, 1'b0})
            begin
                running_sum_next = sum_base + {5'd0, add_word};
            end
            else
            begin
                running_sum_next = sum_base;
            end
            if (last_word)
            begin
                word_index_next = WORD_FIRST;
            end
            else if (word_index_reg < WORD_LIMIT)
            begin
                word_index_next = word_index_reg + 5'd1;
            end
        end
    end

    // verdict sequencer and table walk
    always_comb
    begin
        state_next       = state_reg;
        walk_idx_next    = walk_idx_reg;
        res_verdict_next = res_verdict_reg;
        res_hop_next     = res_hop_reg;
        res_ttl_next     = res_ttl_reg;
        res_csum_next    = res_csum_reg;
        rd_en            = 1'b0;
        rd_idx           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (is_header && last_word)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                res_hop_next  = 32'd0;
                res_ttl_next  = 8'd0;
                res_csum_next = 16'd0;
                if (seen_ttl_reg == 8'd0)
                begin
                    res_verdict_next = VERDICT_TTL_DROP;
                    state_next       = S_PUT;
                end
                else if (seen_dest_reg == local_address_reg)
                begin
                    res_verdict_next = VERDICT_LOCAL;
                    state_next       = S_PUT;
                end
                else if (entry_count_reg == '0)
                begin
                    res_verdict_next = VERDICT_NO_ROUTE;
                    state_next       = S_PUT;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_idx        = '0;
                    walk_idx_next = '0;
                    state_next    = S_WALK;
                end
            end
            S_WALK:
            begin
                if (rd_match)
                begin
                    res_verdict_next = VERDICT_FORWARD;
                    res_hop_next     = rd_hop;
                    res_ttl_next     = ttl_dec;
                    res_csum_next    = checksum;
                    state_next       = S_PUT;
                end
                else if (CNT_W'(walk_idx_reg + 1'b1) == entry_count_reg)
                begin
                    res_verdict_next = VERDICT_NO_ROUTE;
                    state_next       = S_PUT;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_idx        = CNT_W'(walk_idx_reg + 1'b1);
                    walk_idx_next = rd_idx;
                end
            end
            S_PUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            local_address_reg <= 32'd0;
            entry_count_reg   <= '0;
            word_index_reg    <= WORD_FIRST;
            header_words_reg  <= 4'd0;
            seen_ttl_reg      <= 8'd0;
            seen_dest_reg     <= 32'd0;
            running_sum_reg   <= 21'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            entry_count_reg  <= entry_count_next;
            word_index_reg   <= word_index_next;
            header_words_reg <= header_words_next;
            seen_ttl_reg     <= seen_ttl_next;
            seen_dest_reg    <= seen_dest_next;
            running_sum_reg  <= running_sum_next;
            if (cfg_write_en)
            begin
                local_address_reg <= cfg_write_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result and output word registers
    always_ff @(posedge clk)
    begin
        walk_idx_reg    <= walk_idx_next;
        res_verdict_reg <= res_verdict_next;
        res_hop_reg     <= res_hop_next;
        res_ttl_reg     <= res_ttl_next;
        res_csum_reg    <= res_csum_next;
        if (out_load)
        begin
            out_verdict_reg <= res_verdict_reg;
            out_hop_reg     <= res_hop_reg;
            out_ttl_reg     <= res_ttl_reg;
            out_csum_reg    <= res_csum_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign verdict      = out_verdict_reg;
    assign forward_hop  = out_hop_reg;
    assign new_ttl      = out_ttl_reg;
    assign new_checksum = out_csum_reg;

    // checks
    `ASSERT_NEVER(a_count_bound, entry_count_reg > ENTRIES)
    `ASSERT_CLK(a_walk_in_table, (state_reg == S_WALK) |-> (walk_idx_reg < entry_count_reg))
    `ASSERT_CLK(a_result_from_put, $rose(out_valid) |-> $past(state_reg == S_PUT))
    `ASSERT_CLK(a_last_word_busy, (is_header && last_word) |=> !in_ready)

endmodule
